// ----- hw/rtl/prks_pkg.sv -----
`timescale 1ns / 1ps

package prks_pkg;

    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam int POS_W             = 12;
    localparam int SIZE_W            = 40;
    localparam int KSZ_W             = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int SIZE_FIELD_BYTES  = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CKEY_SZ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EKEY_SZ  = 2'd3;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_SIZE  = 3'd1,
        PH_CKEY  = 3'd2,
        PH_EKEY  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FOUND = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_MISS  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [63:0]      key_high;
        logic [63:0]      key_low;
        logic [KSZ_W-1:0] ckey_size;
        logic [KSZ_W-1:0] ekey_size;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        count;
        logic [SIZE_W-1:0] size;
        logic [7:0]        key_byte;
        logic              last;
    } result_t;

endpackage

// ----- hw/rtl/page_record_key_scan_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    page_byte, page_end
// out       result     out_valid / out_ready  result_kind, key_count, decoded_size,
//                                             key_byte, run_last
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One page byte per cycle; a request's result appears in the cycle after acceptance.
// The rate is set by the single result register: in_ready drops only while that
// register holds a result that out_ready does not take.
// Reset clears the record parser to the count phase and loads key sizes of 16.
// cfg_ready is always high.

module page_record_key_scan_unit
    import prks_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            page_byte,
    input  logic                  page_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [7:0]            key_count,
    output logic [SIZE_W-1:0]     decoded_size,
    output logic [7:0]            key_byte,
    output logic                  run_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    logic    take;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    slot_free;

    assign in_ready = slot_free;
    assign take     = in_valid && in_ready;

    prks_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prks_parser #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .page_byte (page_byte),
        .page_end  (page_end),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    prks_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign key_count    = out_res.count;
    assign decoded_size = out_res.size;
    assign key_byte     = out_res.key_byte;
    assign run_last     = out_res.last;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

    a_header_fields_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != KIND_FOUND) |-> (key_count == '0 && decoded_size == '0))
        else $error("header fields set on non-header result");

    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_MISS) |-> run_last)
        else $error("not-found result without run_last");

endmodule

// ----- hw/rtl/prks_cfg.sv -----
`timescale 1ns / 1ps

module prks_cfg
    import prks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_high  <= '0;
            cfg_reg.key_low   <= '0;
            cfg_reg.ckey_size <= KSZ_W'(16);
            cfg_reg.ekey_size <= KSZ_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_HIGH: cfg_reg.key_high  <= cfg_data;
                REG_KEY_LOW:  cfg_reg.key_low   <= cfg_data;
                REG_CKEY_SZ:  cfg_reg.ckey_size <= cfg_data[KSZ_W-1:0];
                REG_EKEY_SZ:  cfg_reg.ekey_size <= cfg_data[KSZ_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/prks_parser.sv -----
`timescale 1ns / 1ps

module prks_parser
    import prks_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] page_byte,
    input  logic       page_end,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [KSZ_W-1:0] MAX_SZ = KSZ_W'(MAX_KEY_BYTES);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic              eq_reg, eq_next;
    logic              found_reg, found_next;

    logic [KSZ_W-1:0]  csz, esz;
    logic [127:0]      key128;
    logic [3:0]        tidx;
    logic [7:0]        tbyte;
    logic              eq_now;
    logic [POS_W:0]    pos_inc;
    logic [POS_W:0]    total;
    logic              ekey_last;

    // clamp size registers into 1..MAX_KEY_BYTES
    assign csz = (cfg.ckey_size == '0) ? KSZ_W'(1) :
                 (cfg.ckey_size > MAX_SZ) ? MAX_SZ : cfg.ckey_size;
    assign esz = (cfg.ekey_size == '0) ? KSZ_W'(1) :
                 (cfg.ekey_size > MAX_SZ) ? MAX_SZ : cfg.ekey_size;

    assign key128    = {cfg.key_high, cfg.key_low};
    assign tidx      = 4'd15 - pos_reg[3:0];
    assign tbyte     = key128[{tidx, 3'b000} +: 8];
    assign eq_now    = eq_reg && (page_byte == tbyte);
    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign total     = (POS_W+1)'(cnt_reg * esz);
    assign ekey_last = pos_inc >= total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            eq_reg    <= 1'b1;
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            eq_reg    <= eq_next;
            found_reg <= found_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        eq_next    = eq_reg;
        found_next = found_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_COUNT:
            begin
                cnt_next   = page_byte;
                acc_next   = '0;
                pos_next   = '0;
                eq_next    = 1'b1;
                phase_next = PH_SIZE;
            end
            PH_SIZE:
            begin
                acc_next = {acc_reg[SIZE_W-9:0], page_byte};
                if (pos_inc >= (POS_W+1)'(SIZE_FIELD_BYTES))
                begin
                    pos_next   = '0;
                    phase_next = PH_CKEY;
                end
                else
                    pos_next = pos_inc[POS_W-1:0];
            end
            PH_CKEY:
            begin
                eq_next  = eq_now;
                pos_next = pos_inc[POS_W-1:0];
                if (pos_inc >= (POS_W+1)'(csz))
                begin
                    pos_next = '0;
                    if (eq_now)
                    begin
                        found_next = 1'b1;
                        res.kind   = KIND_FOUND;
                        res.count  = cnt_reg;
                        res.size   = acc_reg;
                        if (cnt_reg == '0)
                        begin
                            res.last   = 1'b1;
                            res_valid  = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            // if the page ends here there is no room for the keys: the end-of-page miss takes over
                            res_valid  = !page_end;
                            phase_next = PH_EKEY;
                        end
                    end
                    else
                        phase_next = (cnt_reg == '0) ? PH_COUNT : PH_EKEY;
                end
            end
            PH_EKEY:
            begin
                pos_next = pos_inc[POS_W-1:0];
                if (found_reg)
                begin
                    res_valid = 1'b1;
                    if (page_end && !ekey_last)
                    begin
                        res.kind = KIND_MISS;
                        res.last = 1'b1;
                    end
                    else
                    begin
                        res.kind     = KIND_KEY;
                        res.key_byte = page_byte;
                        res.last     = ekey_last;
                    end
                    if (ekey_last)
                        phase_next = PH_DONE;
                end
                else if (ekey_last)
                begin
                    pos_next   = '0;
                    phase_next = PH_COUNT;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_COUNT;
            end
        endcase

        if (page_end)
        begin
            if (!res_valid && phase_reg != PH_DONE)
            begin
                res_valid = 1'b1;
                res       = '0;
                res.kind  = KIND_MISS;
                res.last  = 1'b1;
            end
            phase_next = PH_COUNT;
            pos_next   = '0;
            cnt_next   = '0;
            acc_next   = '0;
            eq_next    = 1'b1;
            found_next = 1'b0;
        end
    end

    a_done_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> found_reg)
        else $error("done phase without a match");

    a_ekey_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EKEY |-> cnt_reg != '0)
        else $error("key phase entered with zero key count");

endmodule

// ----- hw/rtl/prks_out_reg.sv -----
`timescale 1ns / 1ps

module prks_out_reg
    import prks_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    slot_free,
    output result_t out_res
);

    logic    valid_reg;
    result_t data_reg;

    assign out_valid = valid_reg;
    assign out_res   = data_reg;
    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

endmodule
